// ----- hdl/rmx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmx_pkg
// Shared types, constants and the gain matrix decode of the channel remixer.
// ----------------------------------------------------------------------------
package rmx_pkg;

    // channel layout
    localparam int CH_NUM    = 6;
    localparam int CH_IDX_W  = 3;
    localparam int CNT_W     = 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_CNT = 2'd1;
    localparam logic [CNT_W-1:0]     RESET_CNT   = 3'd2;

    // q1.15 gain arithmetic
    localparam int GAIN_SHIFT = 15;
    localparam int GAIN_RT    = 23170;
    localparam int ROUND_HALF = 16384;

    // gain codes
    typedef logic [2:0] t_gain;
    localparam t_gain GN_ZERO    = 3'd0;
    localparam t_gain GN_ONE     = 3'd1;
    localparam t_gain GN_HALF    = 3'd2;
    localparam t_gain GN_QUARTER = 3'd3;
    localparam t_gain GN_RT      = 3'd4;

    typedef t_gain [CH_NUM-1:0] t_gain_row;

    // pipeline advance enables handed to every lane
    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_pipe_ctl;

    // one row of the remix matrix: gains feeding destination channel dc
    function automatic t_gain_row gain_row(input logic [CNT_W-1:0] s,
                                           input logic [CNT_W-1:0] d,
                                           input logic [CH_IDX_W-1:0] dc);
        t_gain_row row;
        logic [CNT_W-1:0] scap;
        logic [CNT_W-1:0] dcap;
        logic [CNT_W-1:0] n;
        row  = {CH_NUM{GN_ZERO}};
        scap = (s > CNT_W'(CH_NUM)) ? CNT_W'(CH_NUM) : s;
        dcap = (d > CNT_W'(CH_NUM)) ? CNT_W'(CH_NUM) : d;
        n    = (scap < dcap) ? scap : dcap;
        if (s == 3'd1 && (d == 3'd2 || d == 3'd4)) begin
            if (dc == 3'd0 || dc == 3'd1) row[0] = GN_ONE;
        end else if (s == 3'd1 && d == 3'd6) begin
            if (dc == 3'd2) row[0] = GN_ONE;
        end else if (s == 3'd2 && d == 3'd1) begin
            if (dc == 3'd0) begin
                row[0] = GN_HALF;
                row[1] = GN_HALF;
            end
        end else if (s == 3'd2 && (d == 3'd4 || d == 3'd6)) begin
            if (dc == 3'd0) row[0] = GN_ONE;
            if (dc == 3'd1) row[1] = GN_ONE;
        end else if (s == 3'd4 && d == 3'd1) begin
            if (dc == 3'd0) begin
                row[0] = GN_QUARTER;
                row[1] = GN_QUARTER;
                row[2] = GN_QUARTER;
                row[3] = GN_QUARTER;
            end
        end else if (s == 3'd4 && d == 3'd2) begin
            if (dc == 3'd0) begin
                row[0] = GN_HALF;
                row[2] = GN_HALF;
            end
            if (dc == 3'd1) begin
                row[1] = GN_HALF;
                row[3] = GN_HALF;
            end
        end else if (s == 3'd4 && d == 3'd6) begin
            if (dc == 3'd0) row[0] = GN_ONE;
            if (dc == 3'd1) row[1] = GN_ONE;
            if (dc == 3'd4) row[2] = GN_ONE;
            if (dc == 3'd5) row[3] = GN_ONE;
        end else if (s == 3'd6 && d == 3'd1) begin
            if (dc == 3'd0) begin
                row[0] = GN_RT;
                row[1] = GN_RT;
                row[2] = GN_ONE;
                row[4] = GN_HALF;
                row[5] = GN_HALF;
            end
        end else if (s == 3'd6 && d == 3'd2) begin
            if (dc == 3'd0) begin
                row[0] = GN_ONE;
                row[2] = GN_RT;
                row[4] = GN_RT;
            end
            if (dc == 3'd1) begin
                row[1] = GN_ONE;
                row[2] = GN_RT;
                row[5] = GN_RT;
            end
        end else if (s == 3'd6 && d == 3'd4) begin
            if (dc == 3'd0) begin
                row[0] = GN_ONE;
                row[2] = GN_RT;
            end
            if (dc == 3'd1) begin
                row[1] = GN_ONE;
                row[2] = GN_RT;
            end
            if (dc == 3'd2) row[4] = GN_ONE;
            if (dc == 3'd3) row[5] = GN_ONE;
        end else begin
            // discrete: channel to channel up to the smaller count
            if (CNT_W'(dc) < n) row[dc] = GN_ONE;
        end
        return row;
    endfunction

endpackage

// ----- hdl/audio_channel_remix_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_channel_remix_top
// Channel down/up mix of one audio frame, accumulated into the destination.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one frame per transaction: six source samples and the six
//   current destination samples. m_axis returns the six remixed destination
//   samples, each saturated to the signed sample range.
//   The cfg channel writes the source count (index 0) and destination count
//   (index 1); it is always ready and must only be written while idle.
//   Six lanes, one per destination channel, each form the gain products in
//   their first stage and the rounded, saturated sum in the second; an
//   output register merges the lanes into one frame.
//   A frame passes lane stage a, lane stage b and the output register on its
//   way to m_axis_tvalid. Throughput is one frame per cycle while the
//   receiver takes every frame, with the two lane stages and the output
//   register all advancing together.
//   Reset sets both counts to 2 and empties the pipeline.
//   When the receiver stalls, the held frame stays on m_axis and empty
//   stages behind it still fill; s_axis_tready drops once all three are full.
// ----------------------------------------------------------------------------
module audio_channel_remix_top import rmx_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // cfg write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_index,
    input  logic [CNT_W-1:0]                      i_cfg_data,
    // input frame
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // fields from bit 0: src_0..src_5, acc_in_0..acc_in_5, zero fill
    input  logic [((2*CH_NUM*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // output frame
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // fields from bit 0: mix_out_0..mix_out_5, zero fill
    output logic [((CH_NUM*SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int OUT_W = ((CH_NUM*SAMPLE_BITS+7)/8)*8;

    logic [CNT_W-1:0]              r_src_cnt;
    logic [CNT_W-1:0]              r_dst_cnt;
    logic                          r_vld_a;
    logic                          r_vld_b;
    logic                          w_can_load;
    t_pipe_ctl                     w_ctl;
    logic [CH_NUM*SAMPLE_BITS-1:0] w_mix;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cnt <= RESET_CNT;
            r_dst_cnt <= RESET_CNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_SRC_CNT) r_src_cnt <= i_cfg_data;
            if (i_cfg_index == REG_DST_CNT) r_dst_cnt <= i_cfg_data;
        end
    end

    // stage advance: a stage moves when it is empty or the next one moves
    assign w_ctl.en_b    = !r_vld_b || w_can_load;
    assign w_ctl.en_a    = !r_vld_a || w_ctl.en_b;
    assign s_axis_tready = w_ctl.en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (w_ctl.en_a) r_vld_a <= s_axis_tvalid;
            if (w_ctl.en_b) r_vld_b <= r_vld_a;
        end
    end

    // one lane per destination channel
    for (genvar k = 0; k < CH_NUM; k++) begin : g_lane
        rmx_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_src  (s_axis_tdata[CH_NUM*SAMPLE_BITS-1:0]),
            .i_acc  (s_axis_tdata[(CH_NUM+k)*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_gain (gain_row(r_src_cnt, r_dst_cnt, CH_IDX_W'(k))),
            .o_mix  (w_mix[k*SAMPLE_BITS +: SAMPLE_BITS])
        );
    end

    // merge and output register
    rmx_out #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .OUT_W      (OUT_W)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (r_vld_b),
        .i_mix         (w_mix),
        .o_can_load    (w_can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef SYNTH
    // an accepted frame lands in the first lane stage
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld_a)
        else $error("accepted frame lost at stage a");

    // a stalled output keeps the frame behind it in the lanes
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_b && m_axis_tvalid && !m_axis_tready) |=> r_vld_b)
        else $error("lane result dropped under stall");

    // output empties when taken with nothing behind it
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !r_vld_b) |=> !m_axis_tvalid)
        else $error("output frame repeated");

    // source count write takes effect
    a_cfg_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == REG_SRC_CNT) |=> r_src_cnt == $past(i_cfg_data))
        else $error("source count write lost");
`endif

endmodule

// ----- hdl/rmx_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmx_lane
// One destination channel: gain products, accumulate, round and saturate.
// ----------------------------------------------------------------------------
module rmx_lane import rmx_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  t_pipe_ctl                     i_ctl,
    input  logic [CH_NUM*SAMPLE_BITS-1:0] i_src,
    input  logic [SAMPLE_BITS-1:0]        i_acc,
    input  t_gain_row                     i_gain,
    output logic [SAMPLE_BITS-1:0]        o_mix
);

    localparam int PROD_W = SAMPLE_BITS + 16;
    localparam int SUM_W  = SAMPLE_BITS + 19;
    localparam int Q_W    = SUM_W - GAIN_SHIFT;

    logic signed [PROD_W-1:0] w_src_ext [CH_NUM];
    logic signed [PROD_W-1:0] n_term    [CH_NUM];
    logic signed [PROD_W-1:0] r_term    [CH_NUM];
    logic [SAMPLE_BITS-1:0]   r_acc;
    logic signed [SUM_W-1:0]  n_sum;
    logic [Q_W-1:0]           w_q;
    logic [Q_W-SAMPLE_BITS:0] w_top;
    logic [SAMPLE_BITS-1:0]   n_mix;
    logic [SAMPLE_BITS-1:0]   r_mix;

    // per-source gain products
    always_comb begin
        for (int k = 0; k < CH_NUM; k++) begin
            w_src_ext[k] = PROD_W'($signed(i_src[k*SAMPLE_BITS +: SAMPLE_BITS]));
            case (i_gain[k])
                GN_ONE:     n_term[k] = w_src_ext[k] <<< GAIN_SHIFT;
                GN_HALF:    n_term[k] = w_src_ext[k] <<< (GAIN_SHIFT - 1);
                GN_QUARTER: n_term[k] = w_src_ext[k] <<< (GAIN_SHIFT - 2);
                GN_RT:      n_term[k] = w_src_ext[k] * PROD_W'(GAIN_RT);
                default:    n_term[k] = '0;
            endcase
        end
    end

    // stage a: products and destination sample
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_term <= n_term;
            r_acc  <= i_acc;
        end
    end

    // accumulate with rounding offset, floor shift
    always_comb begin
        n_sum = (SUM_W'($signed(r_acc)) <<< GAIN_SHIFT) + SUM_W'(ROUND_HALF);
        for (int k = 0; k < CH_NUM; k++) begin
            n_sum = n_sum + SUM_W'(r_term[k]);
        end
    end

    assign w_q   = n_sum[SUM_W-1:GAIN_SHIFT];
    assign w_top = w_q[Q_W-1:SAMPLE_BITS-1];

    // saturate to the sample range
    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            n_mix = w_q[SAMPLE_BITS-1:0];
        end else if (w_q[Q_W-1]) begin
            n_mix = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            n_mix = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // stage b: saturated channel result
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_b) begin
            r_mix <= n_mix;
        end
    end

    assign o_mix = r_mix;

endmodule

// ----- hdl/rmx_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmx_out
// Merges the lane results into one frame and holds it for the receiver.
// ----------------------------------------------------------------------------
module rmx_out import rmx_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int OUT_W       = 144
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [CH_NUM*SAMPLE_BITS-1:0] i_mix,
    output logic                          o_can_load,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_W-1:0]              m_axis_tdata
);

    logic                          r_vld;
    logic [CH_NUM*SAMPLE_BITS-1:0] r_frame;

    assign o_can_load = !r_vld || m_axis_tready;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_can_load) begin
            r_vld <= i_vld;
        end
    end

    // frame register
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_vld) begin
            r_frame <= i_mix;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = OUT_W'(r_frame);

endmodule

// ----- verif/audio_channel_remix_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_channel_remix_checker
// Watches the cfg, input and output channels of the channel remixer, predicts
// each remixed frame from its own copy of the channel counts and compares the
// output frames in order, one destination channel at a time.
// ----------------------------------------------------------------------------
module audio_channel_remix_checker import rmx_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // cfg write channel
    input  logic                                      i_cfg_valid,
    input  logic                                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                      i_cfg_index,
    input  logic [CNT_W-1:0]                          i_cfg_data,
    // input frame channel
    input  logic                                      i_in_valid,
    input  logic                                      i_in_ready,
    input  logic [((2*CH_NUM*SAMPLE_BITS+7)/8)*8-1:0] i_in_data,
    // output frame channel
    input  logic                                      i_out_valid,
    input  logic                                      i_out_ready,
    input  logic [((CH_NUM*SAMPLE_BITS+7)/8)*8-1:0]   i_out_data,
    // status
    output int                                        o_errors,
    output int                                        o_pending
);

    // q1.15 gains
    localparam longint Q_ONE     = 32768;
    localparam longint Q_HALF    = 16384;
    localparam longint Q_QUARTER = 8192;
    localparam longint Q_RT      = 23170;
    localparam int     Q_SHIFT   = 15;

    // saturation bounds
    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef logic [CH_NUM-1:0][SAMPLE_BITS-1:0] t_mix;

    logic [CNT_W-1:0] src_count;
    logic [CNT_W-1:0] dst_count;
    t_mix             mix_due[$];
    int               err_count = 0;
    int               frames_seen = 0;
    int               frames_owed = 0;

    assign o_errors  = err_count;
    assign o_pending = frames_owed;

    // remix one frame and add it into the destination samples
    function automatic t_mix remix(input logic [((2*CH_NUM*SAMPLE_BITS+7)/8)*8-1:0] frame,
                                   input logic [CNT_W-1:0] s,
                                   input logic [CNT_W-1:0] d);
        longint gain [CH_NUM][CH_NUM];
        longint sum;
        int     scap;
        int     dcap;
        int     n;
        t_mix   res;
        for (int dc = 0; dc < CH_NUM; dc++)
            for (int sc = 0; sc < CH_NUM; sc++)
                gain[dc][sc] = 0;
        // gain matrix, rows are destination channels
        if (s == 1 && (d == 2 || d == 4)) begin
            gain[0][0] = Q_ONE;
            gain[1][0] = Q_ONE;
        end else if (s == 1 && d == 6) begin
            gain[2][0] = Q_ONE;
        end else if (s == 2 && d == 1) begin
            gain[0][0] = Q_HALF;
            gain[0][1] = Q_HALF;
        end else if (s == 2 && (d == 4 || d == 6)) begin
            gain[0][0] = Q_ONE;
            gain[1][1] = Q_ONE;
        end else if (s == 4 && d == 1) begin
            for (int sc = 0; sc < 4; sc++)
                gain[0][sc] = Q_QUARTER;
        end else if (s == 4 && d == 2) begin
            gain[0][0] = Q_HALF;
            gain[0][2] = Q_HALF;
            gain[1][1] = Q_HALF;
            gain[1][3] = Q_HALF;
        end else if (s == 4 && d == 6) begin
            gain[0][0] = Q_ONE;
            gain[1][1] = Q_ONE;
            gain[4][2] = Q_ONE;
            gain[5][3] = Q_ONE;
        end else if (s == 6 && d == 1) begin
            gain[0][0] = Q_RT;
            gain[0][1] = Q_RT;
            gain[0][2] = Q_ONE;
            gain[0][4] = Q_HALF;
            gain[0][5] = Q_HALF;
        end else if (s == 6 && d == 2) begin
            gain[0][0] = Q_ONE;
            gain[0][2] = Q_RT;
            gain[0][4] = Q_RT;
            gain[1][1] = Q_ONE;
            gain[1][2] = Q_RT;
            gain[1][5] = Q_RT;
        end else if (s == 6 && d == 4) begin
            gain[0][0] = Q_ONE;
            gain[0][2] = Q_RT;
            gain[1][1] = Q_ONE;
            gain[1][2] = Q_RT;
            gain[2][4] = Q_ONE;
            gain[3][5] = Q_ONE;
        end else begin
            // discrete: channel to channel up to the smaller capped count
            scap = (s > CH_NUM) ? CH_NUM : int'(s);
            dcap = (d > CH_NUM) ? CH_NUM : int'(d);
            n    = (scap < dcap) ? scap : dcap;
            for (int c = 0; c < n; c++)
                gain[c][c] = Q_ONE;
        end
        // accumulate, round half up, saturate
        for (int dc = 0; dc < CH_NUM; dc++) begin
            sum = longint'($signed(frame[(CH_NUM+dc)*SAMPLE_BITS +: SAMPLE_BITS])) * Q_ONE;
            for (int sc = 0; sc < CH_NUM; sc++)
                sum += gain[dc][sc] * longint'($signed(frame[sc*SAMPLE_BITS +: SAMPLE_BITS]));
            sum = (sum + Q_ONE / 2) >>> Q_SHIFT;
            if (sum > SAT_HI)
                sum = SAT_HI;
            else if (sum < SAT_LO)
                sum = SAT_LO;
            res[dc] = sum[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        $display("remix mismatch: %s", msg);
        err_count++;
    endtask

    // track counts, queue predictions, compare output transactions
    always @(posedge i_clk) begin : watch
        t_mix want;
        if (!i_rst_n) begin
            src_count = RESET_CNT;
            dst_count = RESET_CNT;
            mix_due.delete();
            frames_owed <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_SRC_CNT)
                    src_count = i_cfg_data;
                else if (i_cfg_index == REG_DST_CNT)
                    dst_count = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                mix_due.push_back(remix(i_in_data, src_count, dst_count));
            if (i_out_valid && i_out_ready) begin
                if (mix_due.size() == 0) begin
                    report_mismatch($sformatf("frame %0d arrived with none expected",
                                              frames_seen));
                end else begin
                    want = mix_due.pop_front();
                    for (int dc = 0; dc < CH_NUM; dc++) begin
                        if (i_out_data[dc*SAMPLE_BITS +: SAMPLE_BITS] !== want[dc])
                            report_mismatch($sformatf(
                                "frame %0d mix_out_%0d got %0d want %0d", frames_seen, dc,
                                $signed(i_out_data[dc*SAMPLE_BITS +: SAMPLE_BITS]),
                                $signed(want[dc])));
                    end
                end
                frames_seen++;
            end
            frames_owed <= mix_due.size();
        end
    end

endmodule

// ----- verif/tb_audio_channel_remix_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_channel_remix_top
// Drives frames through the channel remixer under a series of channel count
// settings, with random idling on both streams and one long output stall.
// Prediction and comparison live in the checker beside the block.
// ----------------------------------------------------------------------------
module tb_audio_channel_remix_top;
    import rmx_pkg::*;

    localparam int SAMPLE_BITS   = 24;
    localparam int IN_W          = ((2*CH_NUM*SAMPLE_BITS+7)/8)*8;
    localparam int OUT_W         = ((CH_NUM*SAMPLE_BITS+7)/8)*8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_PHASES = 34;
    localparam int PHASE_ITEMS   = 25;
    localparam int HOLD_PHASE    = 20;
    localparam int DRAIN_CYCLES  = 8;

    // register indexes the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_VOID_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOID_3 = 2'd3;

    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] S_ONE = SAMPLE_BITS'(1);
    localparam logic [SAMPLE_BITS-1:0] S_NEG = {SAMPLE_BITS{1'b1}};

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CNT_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;

    int   mix_errors;
    int   mix_owed;
    int   cycle_count = 0;
    bit   tx_idle_on  = 1'b0;
    bit   rx_idle_on  = 1'b0;
    bit   rx_hold_req = 1'b0;

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    audio_channel_remix_top #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    audio_channel_remix_checker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) remix_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (s_axis_tvalid),
        .i_in_ready (s_axis_tready),
        .i_in_data  (s_axis_tdata),
        .i_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_out_data (m_axis_tdata),
        .o_errors   (mix_errors),
        .o_pending  (mix_owed)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_audio_channel_remix_top: errors");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin : rx_side
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // sample with extra weight on the range ends and small values
    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return {{(SAMPLE_BITS-6){r[5]}}, r[5:0]};
            default: return r[SAMPLE_BITS-1:0];
        endcase
    endfunction

    function automatic logic [IN_W-1:0] random_frame();
        logic [IN_W-1:0] w;
        w = '0;
        for (int i = 0; i < 2 * CH_NUM; i++)
            w[i*SAMPLE_BITS +: SAMPLE_BITS] = rand_sample();
        return w;
    endfunction

    function automatic logic [IN_W-1:0] uniform_frame(input logic [SAMPLE_BITS-1:0] src_val,
                                                      input logic [SAMPLE_BITS-1:0] acc_val);
        logic [IN_W-1:0] w;
        w = '0;
        for (int i = 0; i < CH_NUM; i++) begin
            w[i*SAMPLE_BITS +: SAMPLE_BITS]          = src_val;
            w[(CH_NUM+i)*SAMPLE_BITS +: SAMPLE_BITS] = acc_val;
        end
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] draw_count();
        if ($urandom_range(0, 3) == 0)
            return CNT_W'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0:       return 3'd1;
            1:       return 3'd2;
            2:       return 3'd4;
            default: return 3'd6;
        endcase
    endfunction

    // one input transaction, with an optional idle burst ahead of it
    task automatic push_frame(input logic [IN_W-1:0] word);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // one cfg transaction, valid left high for the caller
    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // both counts, optionally preceded by writes to unused indexes
    task automatic set_counts(input logic [CNT_W-1:0] s, input logic [CNT_W-1:0] d,
                              input bit stray);
        if (stray) begin
            cfg_beat(REG_VOID_2, CNT_W'($urandom_range(0, 7)));
            cfg_beat(REG_VOID_3, CNT_W'($urandom_range(0, 7)));
        end
        cfg_beat(REG_SRC_CNT, s);
        cfg_beat(REG_DST_CNT, d);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering and wait until every expected frame has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (mix_owed != 0);
    endtask

    // stimulus and verdict
    initial begin : tx_side
        logic [IN_W-1:0]  w;
        logic [CNT_W-1:0] s;
        logic [CNT_W-1:0] d;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset counts, range ends and alternating bits
        push_frame(uniform_frame('0, '0));
        push_frame(uniform_frame(S_MAX, S_MAX));
        push_frame(uniform_frame(S_MIN, S_MIN));
        push_frame(uniform_frame(S_MAX, S_MIN));
        push_frame(uniform_frame({(SAMPLE_BITS/2){2'b01}}, {(SAMPLE_BITS/2){2'b10}}));

        // 6 -> 1 has the largest gain sum: saturation both ways
        wait_drained();
        set_counts(3'd6, 3'd1, 1'b1);
        push_frame(uniform_frame(S_MAX, S_MAX));
        push_frame(uniform_frame(S_MIN, S_MIN));
        push_frame(uniform_frame(S_MIN, S_MAX));

        // 2 -> 1 halves: rounding ties go toward plus infinity
        wait_drained();
        set_counts(3'd2, 3'd1, 1'b0);
        w = random_frame();
        w[0 +: 2*SAMPLE_BITS] = {SAMPLE_BITS'(0), S_ONE};
        w[CH_NUM*SAMPLE_BITS +: SAMPLE_BITS] = '0;
        push_frame(w);
        w[0 +: 2*SAMPLE_BITS] = {SAMPLE_BITS'(0), S_NEG};
        push_frame(w);
        w[0 +: 2*SAMPLE_BITS] = {S_NEG, S_NEG - S_ONE};
        push_frame(w);

        // zero source count: no source is mixed in, destination samples pass through
        wait_drained();
        set_counts(3'd0, 3'd6, 1'b0);
        push_frame(random_frame());
        push_frame(uniform_frame(S_MAX, S_MIN));

        // count of seven is capped to six
        wait_drained();
        set_counts(3'd7, 3'd7, 1'b1);
        push_frame(random_frame());
        push_frame(random_frame());

        wait_drained();
        set_counts(3'd4, 3'd2, 1'b0);
        push_frame(random_frame());
        wait_drained();
        set_counts(3'd1, 3'd6, 1'b0);
        push_frame(random_frame());

        // random frames, every matrix first, then fixed discrete pairs, then random count pairs
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            case (p)
                0:       {s, d} = {3'd1, 3'd2};
                1:       {s, d} = {3'd1, 3'd4};
                2:       {s, d} = {3'd1, 3'd6};
                3:       {s, d} = {3'd2, 3'd1};
                4:       {s, d} = {3'd2, 3'd4};
                5:       {s, d} = {3'd2, 3'd6};
                6:       {s, d} = {3'd4, 3'd1};
                7:       {s, d} = {3'd4, 3'd2};
                8:       {s, d} = {3'd4, 3'd6};
                9:       {s, d} = {3'd6, 3'd1};
                10:      {s, d} = {3'd6, 3'd2};
                11:      {s, d} = {3'd6, 3'd4};
                12:      {s, d} = {3'd0, 3'd3};
                13:      {s, d} = {3'd7, 3'd5};
                14:      {s, d} = {3'd3, 3'd7};
                15:      {s, d} = {3'd5, 3'd5};
                default: {s, d} = {draw_count(), draw_count()};
            endcase
            set_counts(s, d, (p % 8) == 0);
            // no idling in the closing phases
            tx_idle_on = (p < RANDOM_PHASES - 3) && ($urandom_range(0, 3) != 0);
            rx_idle_on <= (p < RANDOM_PHASES - 3) && ($urandom_range(0, 3) != 0);
            // long output stall while the sender keeps offering frames
            if (p == HOLD_PHASE) begin
                tx_idle_on = 1'b0;
                rx_hold_req <= 1'b1;
            end
            repeat (PHASE_ITEMS) push_frame(random_frame());
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mix_errors == 0)
            $display("tb_audio_channel_remix_top: clean");
        else
            $display("tb_audio_channel_remix_top: errors");
        $finish;
    end

endmodule

// ----- audio_channel_remix_top.f -----
hdl/rmx_pkg.sv
hdl/rmx_lane.sv
hdl/rmx_out.sv
hdl/audio_channel_remix_top.sv
verif/audio_channel_remix_checker.sv
verif/tb_audio_channel_remix_top.sv
